// ===== sv/abm_pkg.sv =====
// Shared types, codes and fixed-point constants for the 2D bilinear map.
// No dependencies; every other file refers to this package by scoped names.
package abm_pkg;

    localparam int DATA_W       = 32;
    localparam int FRAC_BITS    = 16;
    localparam int T_W          = FRAC_BITS + 1;
    localparam int SIZE_W       = 5;
    localparam int IDX_W        = 4;
    localparam int FUNC_W       = 4;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 4;
    localparam int DIV_W        = DATA_W + 2;
    localparam int MUL_A_W      = DATA_W + 2;
    localparam int MUL_B_W      = T_W + 2;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int RND_W        = PROD_W - FRAC_BITS;
    localparam int SUM_W        = RND_W + 1;
    localparam int DEF_MAX_COLS = 16;
    localparam int DEF_MAX_ROWS = 16;

    localparam logic [T_W-1:0] ONE_T = T_W'(1) << FRAC_BITS;

    localparam logic [FUNC_W-1:0] FN_INIT     = 4'd0;
    localparam logic [FUNC_W-1:0] FN_SETX     = 4'd1;
    localparam logic [FUNC_W-1:0] FN_SETY     = 4'd2;
    localparam logic [FUNC_W-1:0] FN_SETCELL  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_FILL     = 4'd4;
    localparam logic [FUNC_W-1:0] FN_READCELL = 4'd5;
    localparam logic [FUNC_W-1:0] FN_READX    = 4'd6;
    localparam logic [FUNC_W-1:0] FN_READY    = 4'd7;
    localparam logic [FUNC_W-1:0] FN_SAMPLE   = 4'd8;
    localparam logic [FUNC_W-1:0] FN_ACCUM    = 4'd9;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOINIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_X_SIZE     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH = 4'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [IDX_W-1:0]         col_index;
        logic [IDX_W-1:0]         row_index;
        logic signed [DATA_W-1:0] write_data;
        logic signed [DATA_W-1:0] x_coord;
        logic signed [DATA_W-1:0] y_coord;
        logic signed [DATA_W-1:0] delta;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic [STATUS_W-1:0]      status;
    } rsp_t;

endpackage

// ===== sv/abm_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with a registered read.
// Depends on abm_pkg for the data width.
module abm_ram #(
    parameter int DEPTH = abm_pkg::DEF_MAX_COLS,
    parameter int AW    = 4
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [abm_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [abm_pkg::DATA_W-1:0] rdata
);

    logic [abm_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/abm_div.sv =====
// Restoring serial divider for the interpolation fraction, one quotient bit a cycle.
// Depends on abm_pkg; expects a positive dividend below the divisor.
module abm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [abm_pkg::DIV_W-1:0]     dividend,
    input  logic [abm_pkg::DIV_W-1:0]     divisor,
    output logic                          done,
    output logic [abm_pkg::FRAC_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(abm_pkg::FRAC_BITS + 1);

    logic [abm_pkg::DIV_W:0]       rem_reg;
    logic [abm_pkg::DIV_W-1:0]     den_reg;
    logic [abm_pkg::FRAC_BITS-1:0] q_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [abm_pkg::DIV_W:0]       shifted;
    logic                          fits;

    assign shifted  = {rem_reg[abm_pkg::DIV_W-1:0], 1'b0};
    assign fits     = shifted >= {1'b0, den_reg};
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= {1'b0, dividend};
                den_reg  <= divisor;
                q_reg    <= '0;
                cnt_reg  <= CNT_W'(abm_pkg::FRAC_BITS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? (shifted - {1'b0, den_reg}) : shifted;
                q_reg   <= {q_reg[abm_pkg::FRAC_BITS-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== sv/adaptive_bilinear_map_2d.sv =====
// A 2D map of signed Q16.16 cells over ascending X and Y breakpoint axes, kept in
// synchronous RAMs, with one result word per request word. Init and fill write
// all active_rows*active_cols cells, one cell write a cycle. Sample and accumulate
// search each axis through the axis RAM's single read port (a binary search, cut
// short when the coordinate lies at or beyond an axis end), then check the span,
// wait for the serial divide when the point falls inside an interval, and store
// the axis result. Sample then reads the four corners and blends them; accumulate
// reads, updates and writes back each corner with a nonzero weight and skips each
// other corner. No clearing pass runs after reset; the map is undefined until init.
// Depends on abm_pkg, abm_ram and abm_div.
module adaptive_bilinear_map_2d #(
    parameter int MAX_COLS = abm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = abm_pkg::DEF_MAX_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  abm_pkg::req_t                     req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output abm_pkg::rsp_t                     rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [abm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [abm_pkg::DATA_W-1:0]        cfg_data
);

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int CAW   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int XAW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int YAW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SW    = abm_pkg::SIZE_W;
    localparam int DW    = abm_pkg::DATA_W;
    localparam int TW    = abm_pkg::T_W;
    localparam int FB    = abm_pkg::FRAC_BITS;
    localparam int AW_M  = abm_pkg::MUL_A_W;
    localparam int BW_M  = abm_pkg::MUL_B_W;
    localparam int PW    = abm_pkg::PROD_W;
    localparam int RW    = abm_pkg::RND_W;
    localparam int SUMW  = abm_pkg::SUM_W;
    localparam int DVW   = abm_pkg::DIV_W;

    localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((longint'(1) << (DW - 1)) - longint'(1));
    localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_SWEEP = 5'd2;
    localparam logic [4:0] S_RDW   = 5'd3;
    localparam logic [4:0] S_A0    = 5'd4;
    localparam logic [4:0] S_A0D   = 5'd5;
    localparam logic [4:0] S_AND   = 5'd6;
    localparam logic [4:0] S_MID   = 5'd7;
    localparam logic [4:0] S_MIDD  = 5'd8;
    localparam logic [4:0] S_SPAN  = 5'd9;
    localparam logic [4:0] S_DIVW  = 5'd10;
    localparam logic [4:0] S_AXEND = 5'd11;
    localparam logic [4:0] S_CRD   = 5'd12;
    localparam logic [4:0] S_CRDD  = 5'd13;
    localparam logic [4:0] S_L0    = 5'd14;
    localparam logic [4:0] S_L1    = 5'd15;
    localparam logic [4:0] S_L2    = 5'd16;
    localparam logic [4:0] S_L3    = 5'd17;
    localparam logic [4:0] S_L4    = 5'd18;
    localparam logic [4:0] S_AW    = 5'd19;
    localparam logic [4:0] S_AW2   = 5'd20;
    localparam logic [4:0] S_AM    = 5'd21;
    localparam logic [4:0] S_AWR   = 5'd22;
    localparam logic [4:0] S_FIN   = 5'd23;

    function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] p);
        logic [PW-1:0] s;
        s = p + (PW'(1) << (FB - 1));
        return s[PW-1:FB];
    endfunction

    function automatic logic signed [DW-1:0] sat(input logic signed [SUMW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[DW-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[DW-1:0];
        end
        else
        begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic [SW-1:0] fit_size(input logic [SW-1:0] v, input int maxv);
        logic [SW-1:0] r;
        if (v == '0)
        begin
            r = SW'(1);
        end
        else if (int'(v) > maxv)
        begin
            r = SW'(maxv);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    logic [4:0]              state_reg;
    logic [SW-1:0]           x_size_reg;
    logic [SW-1:0]           y_size_reg;
    logic signed [DW-1:0]    clamp_low_reg;
    logic signed [DW-1:0]    clamp_high_reg;
    logic [SW-1:0]           cols_reg;
    logic [SW-1:0]           rows_reg;
    logic                    map_ready_reg;
    abm_pkg::req_t           req_reg;
    logic signed [DW-1:0]    rd_reg;
    logic [1:0]              st_reg;
    abm_pkg::rsp_t           rsp_reg;
    logic                    rsp_valid_reg;
    logic [SW-1:0]           r_reg;
    logic [SW-1:0]           c_reg;
    logic                    init_sweep_reg;
    logic                    ax_y_reg;
    logic [SW-1:0]           lo_reg;
    logic [SW-1:0]           hi_reg;
    logic [SW-1:0]           mid_reg;
    logic signed [DW-1:0]    a_lo_reg;
    logic signed [DW-1:0]    a_hi_reg;
    logic [TW-1:0]           t_cur_reg;
    logic [TW-1:0]           tx_reg;
    logic [TW-1:0]           ty_reg;
    logic [SW-1:0]           i0_reg;
    logic [SW-1:0]           j0_reg;
    logic [1:0]              k_reg;
    logic signed [DW-1:0]    c_val_reg [4];
    logic signed [AW_M-1:0]  v0_reg;
    logic signed [AW_M-1:0]  v1_reg;
    logic signed [BW_M-1:0]  w_reg;
    logic signed [DW-1:0]    cell_reg;
    logic signed [PW-1:0]    prod_reg;

    logic [abm_pkg::FUNC_W-1:0] func;
    logic                    col_ok;
    logic                    row_ok;
    logic [SW-1:0]           n_cur;
    logic signed [DW-1:0]    v_cur;
    logic [SW:0]             mid_sum;
    logic [SW-1:0]           mid_c;
    logic [SW-1:0]           srch_addr;
    logic [SW-1:0]           i1;
    logic [SW-1:0]           j1;
    logic [SW-1:0]           ci;
    logic [SW-1:0]           cj;
    logic [CAW-1:0]          corner_addr;
    logic [CAW-1:0]          sweep_addr;
    logic [CAW-1:0]          req_addr;
    logic [TW-1:0]           ax_k;
    logic [TW-1:0]           ay_k;
    logic signed [DVW-1:0]   span;
    logic signed [DVW-1:0]   off;
    logic signed [AW_M-1:0]  mul_a;
    logic signed [BW_M-1:0]  mul_b;
    logic signed [PW-1:0]    mul_p;
    logic signed [SUMW-1:0]  lerp_sum;
    logic signed [SUMW-1:0]  nv;
    logic signed [SUMW-1:0]  nv_lo;
    logic signed [SUMW-1:0]  nv_cl;
    logic                    fin_go;
    logic                    div_start;
    logic                    div_done;
    logic [FB-1:0]           div_q;

    logic                    x_we;
    logic [XAW-1:0]          x_waddr;
    logic [DW-1:0]           x_wdata;
    logic [XAW-1:0]          x_raddr;
    logic [DW-1:0]           x_rdata;
    logic                    y_we;
    logic [YAW-1:0]          y_waddr;
    logic [DW-1:0]           y_wdata;
    logic [YAW-1:0]          y_raddr;
    logic [DW-1:0]           y_rdata;
    logic                    c_we;
    logic [CAW-1:0]          c_waddr;
    logic [DW-1:0]           c_wdata;
    logic [CAW-1:0]          c_raddr;
    logic [DW-1:0]           c_rdata;
    logic signed [DW-1:0]    ax_rd;
    logic signed [DW-1:0]    cell_rd;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    assign func    = req_reg.func;
    assign col_ok  = {1'b0, req_reg.col_index} < cols_reg;
    assign row_ok  = {1'b0, req_reg.row_index} < rows_reg;
    assign n_cur   = ax_y_reg ? rows_reg : cols_reg;
    assign v_cur   = ax_y_reg ? req_reg.y_coord : req_reg.x_coord;
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_c   = mid_sum[SW:1];
    assign i1      = (cols_reg > SW'(1)) ? i0_reg + SW'(1) : i0_reg;
    assign j1      = (rows_reg > SW'(1)) ? j0_reg + SW'(1) : j0_reg;
    assign ci      = k_reg[0] ? i1 : i0_reg;
    assign cj      = k_reg[1] ? j1 : j0_reg;
    assign ax_k    = k_reg[0] ? tx_reg : abm_pkg::ONE_T - tx_reg;
    assign ay_k    = k_reg[1] ? ty_reg : abm_pkg::ONE_T - ty_reg;
    assign span    = DVW'(a_hi_reg) - DVW'(a_lo_reg);
    assign off     = DVW'(v_cur) - DVW'(a_lo_reg);
    assign ax_rd   = ax_y_reg ? $signed(y_rdata) : $signed(x_rdata);
    assign cell_rd = $signed(c_rdata);

    assign corner_addr = CAW'(int'(cj) * MAX_COLS + int'(ci));
    assign sweep_addr  = CAW'(int'(r_reg) * MAX_COLS + int'(c_reg));
    assign req_addr    = CAW'(int'(req_reg.row_index) * MAX_COLS + int'(req_reg.col_index));

    assign fin_go    = (state_reg == S_FIN) && (!rsp_valid_reg || rsp_ready);
    assign div_start = (state_reg == S_SPAN) && (span > 0) && (off > 0) && (off < span);

    // Search read address: first breakpoint, then the last, then midpoints.
    always_comb
    begin
        case (state_reg)
            S_A0D:   srch_addr = n_cur - SW'(1);
            S_MID:   srch_addr = mid_c;
            default: srch_addr = '0;
        endcase
    end

    assign x_raddr = (state_reg == S_DISP) ? XAW'(req_reg.col_index) : XAW'(srch_addr);
    assign y_raddr = (state_reg == S_DISP) ? YAW'(req_reg.row_index) : YAW'(srch_addr);

    always_comb
    begin
        x_we    = 1'b0;
        y_we    = 1'b0;
        x_waddr = XAW'(req_reg.col_index);
        y_waddr = YAW'(req_reg.row_index);
        x_wdata = req_reg.write_data;
        y_wdata = req_reg.write_data;
        if (state_reg == S_SWEEP)
        begin
            x_we    = init_sweep_reg && (r_reg == '0);
            y_we    = init_sweep_reg && (c_reg == '0);
            x_waddr = XAW'(c_reg);
            y_waddr = YAW'(r_reg);
            x_wdata = DW'(c_reg) << FB;
            y_wdata = DW'(r_reg) << FB;
        end
        else if (state_reg == S_DISP && map_ready_reg)
        begin
            x_we = (func == abm_pkg::FN_SETX) && col_ok;
            y_we = (func == abm_pkg::FN_SETY) && row_ok;
        end
    end

    always_comb
    begin
        c_we    = 1'b0;
        c_waddr = req_addr;
        c_wdata = req_reg.write_data;
        c_raddr = (state_reg == S_DISP) ? req_addr : corner_addr;
        case (state_reg)
            S_DISP:
            begin
                c_we = map_ready_reg && (func == abm_pkg::FN_SETCELL) && col_ok && row_ok;
            end
            S_SWEEP:
            begin
                c_we    = 1'b1;
                c_waddr = sweep_addr;
            end
            S_AWR:
            begin
                c_we    = 1'b1;
                c_waddr = corner_addr;
                c_wdata = nv_cl[DW-1:0];
            end
            default:
            begin
                c_we = 1'b0;
            end
        endcase
    end

    // One shared multiplier; its operands follow the step in progress.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_L0:
            begin
                mul_a = AW_M'(c_val_reg[1]) - AW_M'(c_val_reg[0]);
                mul_b = $signed({2'b00, tx_reg});
            end
            S_L1:
            begin
                mul_a = AW_M'(c_val_reg[3]) - AW_M'(c_val_reg[2]);
                mul_b = $signed({2'b00, tx_reg});
            end
            S_L3:
            begin
                mul_a = v1_reg - v0_reg;
                mul_b = $signed({2'b00, ty_reg});
            end
            S_AW:
            begin
                mul_a = $signed({{(AW_M-TW){1'b0}}, ax_k});
                mul_b = $signed({2'b00, ay_k});
            end
            S_AM:
            begin
                mul_a = AW_M'(req_reg.delta);
                mul_b = w_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        case (state_reg)
            S_L1:    lerp_sum = SUMW'(c_val_reg[0]) + SUMW'(rnd(prod_reg));
            S_L2:    lerp_sum = SUMW'(c_val_reg[2]) + SUMW'(rnd(prod_reg));
            default: lerp_sum = SUMW'(v0_reg) + SUMW'(rnd(prod_reg));
        endcase
    end

    // Limits apply low first, so the upper limit wins when they cross.
    assign nv    = SUMW'(cell_reg) + SUMW'(rnd(prod_reg));
    assign nv_lo = (nv < SUMW'(clamp_low_reg)) ? SUMW'(clamp_low_reg) : nv;
    assign nv_cl = (nv_lo > SUMW'(clamp_high_reg)) ? SUMW'(clamp_high_reg) : nv_lo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_size_reg     <= SW'(16);
            y_size_reg     <= SW'(16);
            clamp_low_reg  <= {1'b1, {(DW-1){1'b0}}};
            clamp_high_reg <= {1'b0, {(DW-1){1'b1}}};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                abm_pkg::REG_X_SIZE:     x_size_reg     <= cfg_data[SW-1:0];
                abm_pkg::REG_Y_SIZE:     y_size_reg     <= cfg_data[SW-1:0];
                abm_pkg::REG_CLAMP_LOW:  clamp_low_reg  <= cfg_data;
                abm_pkg::REG_CLAMP_HIGH: clamp_high_reg <= cfg_data;
                default:                 x_size_reg     <= x_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else if (fin_go)
        begin
            rsp_valid_reg <= 1'b1;
            rsp_reg       <= '{read_data: rd_reg, status: st_reg};
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cols_reg       <= '0;
            rows_reg       <= '0;
            map_ready_reg  <= 1'b0;
            req_reg        <= '0;
            rd_reg         <= '0;
            st_reg         <= abm_pkg::ST_OK;
            r_reg          <= '0;
            c_reg          <= '0;
            init_sweep_reg <= 1'b0;
            ax_y_reg       <= 1'b0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            mid_reg        <= '0;
            a_lo_reg       <= '0;
            a_hi_reg       <= '0;
            t_cur_reg      <= '0;
            tx_reg         <= '0;
            ty_reg         <= '0;
            i0_reg         <= '0;
            j0_reg         <= '0;
            k_reg          <= '0;
            c_val_reg      <= '{default: '0};
            v0_reg         <= '0;
            v1_reg         <= '0;
            w_reg          <= '0;
            cell_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg   <= req;
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    rd_reg    <= '0;
                    st_reg    <= abm_pkg::ST_OK;
                    state_reg <= S_FIN;
                    r_reg     <= '0;
                    c_reg     <= '0;
                    ax_y_reg  <= 1'b0;
                    if (func > abm_pkg::FN_ACCUM)
                    begin
                        st_reg <= abm_pkg::ST_OK;
                    end
                    else if (func == abm_pkg::FN_INIT)
                    begin
                        cols_reg       <= fit_size(x_size_reg, MAX_COLS);
                        rows_reg       <= fit_size(y_size_reg, MAX_ROWS);
                        map_ready_reg  <= 1'b1;
                        init_sweep_reg <= 1'b1;
                        state_reg      <= S_SWEEP;
                    end
                    else if (!map_ready_reg)
                    begin
                        st_reg <= abm_pkg::ST_NOINIT;
                    end
                    else if (func == abm_pkg::FN_SETX || func == abm_pkg::FN_READX)
                    begin
                        if (!col_ok)
                            st_reg <= abm_pkg::ST_RANGE;
                        else if (func == abm_pkg::FN_READX)
                            state_reg <= S_RDW;
                    end
                    else if (func == abm_pkg::FN_SETY || func == abm_pkg::FN_READY)
                    begin
                        if (!row_ok)
                            st_reg <= abm_pkg::ST_RANGE;
                        else if (func == abm_pkg::FN_READY)
                            state_reg <= S_RDW;
                    end
                    else if (func == abm_pkg::FN_SETCELL || func == abm_pkg::FN_READCELL)
                    begin
                        if (!col_ok || !row_ok)
                            st_reg <= abm_pkg::ST_RANGE;
                        else if (func == abm_pkg::FN_READCELL)
                            state_reg <= S_RDW;
                    end
                    else if (func == abm_pkg::FN_FILL)
                    begin
                        init_sweep_reg <= 1'b0;
                        state_reg      <= S_SWEEP;
                    end
                    else
                    begin
                        state_reg <= S_A0;
                    end
                end
                S_SWEEP:
                begin
                    if (c_reg + SW'(1) == cols_reg)
                    begin
                        c_reg <= '0;
                        if (r_reg + SW'(1) == rows_reg)
                            state_reg <= S_FIN;
                        else
                            r_reg <= r_reg + SW'(1);
                    end
                    else
                    begin
                        c_reg <= c_reg + SW'(1);
                    end
                end
                S_RDW:
                begin
                    case (func)
                        abm_pkg::FN_READX: rd_reg <= $signed(x_rdata);
                        abm_pkg::FN_READY: rd_reg <= $signed(y_rdata);
                        default:           rd_reg <= cell_rd;
                    endcase
                    state_reg <= S_FIN;
                end
                S_A0:
                begin
                    state_reg <= S_A0D;
                end
                S_A0D:
                begin
                    if (n_cur <= SW'(1) || v_cur <= ax_rd)
                    begin
                        t_cur_reg <= '0;
                        lo_reg    <= '0;
                        state_reg <= S_AXEND;
                    end
                    else
                    begin
                        a_lo_reg  <= ax_rd;
                        state_reg <= S_AND;
                    end
                end
                S_AND:
                begin
                    if (v_cur >= ax_rd)
                    begin
                        t_cur_reg <= abm_pkg::ONE_T;
                        lo_reg    <= n_cur - SW'(2);
                        state_reg <= S_AXEND;
                    end
                    else
                    begin
                        a_hi_reg  <= ax_rd;
                        lo_reg    <= '0;
                        hi_reg    <= n_cur - SW'(1);
                        state_reg <= S_MID;
                    end
                end
                S_MID:
                begin
                    if (hi_reg - lo_reg > SW'(1))
                    begin
                        mid_reg   <= mid_c;
                        state_reg <= S_MIDD;
                    end
                    else
                    begin
                        state_reg <= S_SPAN;
                    end
                end
                S_MIDD:
                begin
                    if (ax_rd <= v_cur)
                    begin
                        lo_reg   <= mid_reg;
                        a_lo_reg <= ax_rd;
                    end
                    else
                    begin
                        hi_reg   <= mid_reg;
                        a_hi_reg <= ax_rd;
                    end
                    state_reg <= S_MID;
                end
                S_SPAN:
                begin
                    if (div_start)
                    begin
                        state_reg <= S_DIVW;
                    end
                    else
                    begin
                        // A fraction of one or more saturates; a flat or inverted span gives zero.
                        t_cur_reg <= (span > 0 && off > 0) ? abm_pkg::ONE_T : '0;
                        state_reg <= S_AXEND;
                    end
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        t_cur_reg <= {1'b0, div_q};
                        state_reg <= S_AXEND;
                    end
                end
                S_AXEND:
                begin
                    k_reg <= '0;
                    if (!ax_y_reg)
                    begin
                        tx_reg    <= t_cur_reg;
                        i0_reg    <= lo_reg;
                        ax_y_reg  <= 1'b1;
                        state_reg <= S_A0;
                    end
                    else
                    begin
                        ty_reg    <= t_cur_reg;
                        j0_reg    <= lo_reg;
                        state_reg <= (func == abm_pkg::FN_SAMPLE) ? S_CRD : S_AW;
                    end
                end
                S_CRD:
                begin
                    state_reg <= S_CRDD;
                end
                S_CRDD:
                begin
                    c_val_reg[k_reg] <= cell_rd;
                    k_reg            <= k_reg + 2'd1;
                    state_reg        <= (k_reg == 2'd3) ? S_L0 : S_CRD;
                end
                S_L0:
                begin
                    state_reg <= S_L1;
                end
                S_L1:
                begin
                    v0_reg    <= lerp_sum[AW_M-1:0];
                    state_reg <= S_L2;
                end
                S_L2:
                begin
                    v1_reg    <= lerp_sum[AW_M-1:0];
                    state_reg <= S_L3;
                end
                S_L3:
                begin
                    state_reg <= S_L4;
                end
                S_L4:
                begin
                    rd_reg    <= sat(lerp_sum);
                    state_reg <= S_FIN;
                end
                S_AW:
                begin
                    state_reg <= S_AW2;
                end
                S_AW2:
                begin
                    // Corners with an exact weight of zero are left untouched.
                    if (prod_reg == '0)
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= (k_reg == 2'd3) ? S_FIN : S_AW;
                    end
                    else
                    begin
                        w_reg     <= BW_M'(rnd(prod_reg));
                        cell_reg  <= cell_rd;
                        state_reg <= S_AM;
                    end
                end
                S_AM:
                begin
                    state_reg <= S_AWR;
                end
                S_AWR:
                begin
                    // The write lands before the next corner's read, so shared corners chain.
                    k_reg     <= k_reg + 2'd1;
                    state_reg <= (k_reg == 2'd3) ? S_FIN : S_AW;
                end
                S_FIN:
                begin
                    if (fin_go)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    abm_ram #(.DEPTH(MAX_COLS), .AW(XAW)) u_x_axis (
        .clk   (clk),
        .we    (x_we),
        .waddr (x_waddr),
        .wdata (x_wdata),
        .raddr (x_raddr),
        .rdata (x_rdata)
    );

    abm_ram #(.DEPTH(MAX_ROWS), .AW(YAW)) u_y_axis (
        .clk   (clk),
        .we    (y_we),
        .waddr (y_waddr),
        .wdata (y_wdata),
        .raddr (y_raddr),
        .rdata (y_rdata)
    );

    abm_ram #(.DEPTH(CELLS), .AW(CAW)) u_cells (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    abm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (off),
        .divisor  (span),
        .done     (div_done),
        .quotient (div_q)
    );

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVW))
        else $error("divider finished outside its wait step");

    a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIDD) |-> (lo_reg < mid_reg && mid_reg < hi_reg))
        else $error("binary search midpoint left its interval");

    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AXEND) |-> (t_cur_reg <= abm_pkg::ONE_T))
        else $error("interpolation fraction above one");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> (rsp_valid_reg && state_reg == S_IDLE))
        else $error("finished word not presented");

endmodule
